### hdl/pce_pkg.sv
// Shared constants and types of the PCA projection engine.
package pce_pkg;

	// Table sizes and index widths.
	localparam int MAX_DIMS       = 64;
	localparam int COMP_SLOTS     = 16;
	localparam int DIM_W          = $clog2(MAX_DIMS);
	localparam int COMP_W         = $clog2(COMP_SLOTS);
	localparam int WADDR_W        = COMP_W + DIM_W;

	// Configuration register widths and indexes.
	localparam int DIMS_CFG_W  = 7;
	localparam int COMPS_CFG_W = 5;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_IDX_W   = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPONENTS_IN_USE = 1'b1;
	localparam logic [DIMS_CFG_W-1:0]  DIMS_RESET  = 7'd64;
	localparam logic [COMPS_CFG_W-1:0] COMPS_RESET = 5'd16;

	// Datapath widths.
	localparam int COEF_W = 16;
	localparam int BYTE_W = 8;
	localparam int DIFF_W = 18;
	localparam int PROD_W = DIFF_W + COEF_W;
	localparam int ACC_W  = 40;

	// Stream widths.
	localparam int CMD_W     = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	// Item commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_MEAN   = 2'd0,
		CMD_LOAD_WEIGHT = 2'd1,
		CMD_SAMPLE      = 2'd2,
		CMD_UNUSED      = 2'd3
	} cmd_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MEAN = 4'b0010,
		ST_MAC  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

### hdl/pca_projection_engine.sv
// Top level of the PCA projection engine: sequencer, shared multiply-accumulate and output stage.
//
// Load items (mean or weight) leave the block ready for the next item. A sample item keeps
// the block busy from its accept to the next possible accept: first the mean is read, then
// one weight read and one multiply-accumulate per component through the single 18x16
// multiplier and 40-bit adder, and then that pipeline drains. The sample at the last element
// in use then emits one result per component in use, one per cycle while the output side takes
// them, and clears the accumulators. The mean and weight tables hold whatever was last loaded;
// a table entry that was never loaded reads as garbage.
module pca_projection_engine
	import pce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Input items.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: element_index[5:0], component_index[9:6], coefficient[25:10],
	// sample_byte[33:26], zero fill[39:34]
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,
	// tuser: command[1:0]
	input  logic [CMD_W-1:0]       s_axis_tuser,
	// Result items.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: component_number[3:0], projection[43:4], zero fill[47:44]
	output logic [M_TDATA_W-1:0]   m_axis_tdata,
	// tlast: last_component
	output logic                   m_axis_tlast
);

	// Input field unpacking.
	cmd_t                     in_cmd;
	logic [DIM_W-1:0]         in_elem;
	logic [COMP_W-1:0]        in_comp;
	logic [COEF_W-1:0]        in_coef;
	logic [BYTE_W-1:0]        in_byte;
	logic                     s_accept;

	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_elem  = s_axis_tdata[5:0];
	assign in_comp  = s_axis_tdata[9:6];
	assign in_coef  = s_axis_tdata[25:10];
	assign in_byte  = s_axis_tdata[33:26];
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	logic [DIMS_CFG_W-1:0]  dims_q;
	logic [COMPS_CFG_W-1:0] comps_q;
	logic [DIMS_CFG_W-1:0]  dims_eff;
	logic [COMPS_CFG_W-1:0] comps_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_RESET;
			comps_q <= COMPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIMS_IN_USE:       dims_q  <= cfg_data;
				REG_COMPONENTS_IN_USE: comps_q <= cfg_data[COMPS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate the registers to their legal ranges.
	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DIMS_CFG_W'(1);
		end else if (dims_q > DIMS_CFG_W'(MAX_DIMS)) begin
			dims_eff = DIMS_CFG_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
		if (comps_q == '0) begin
			comps_eff = COMPS_CFG_W'(1);
		end else if (comps_q > COMPS_CFG_W'(COMP_SLOTS)) begin
			comps_eff = COMPS_CFG_W'(COMP_SLOTS);
		end else begin
			comps_eff = comps_q;
		end
	end

	// Sequencer and sample registers.
	state_t                  state_q;
	logic [DIM_W-1:0]        elem_q;
	logic [BYTE_W-1:0]       byte_q;
	logic                    last_elem_q;
	logic [COMPS_CFG_W-1:0]  issue_q;
	logic [COMP_W-1:0]       emit_k_q;
	logic                    rd_s1;
	logic                    sample_ok;
	logic                    issuing;
	logic                    mac_done;
	logic                    emit_load;
	logic                    emit_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign sample_ok = (in_cmd == CMD_SAMPLE) && ({1'b0, in_elem} < dims_eff);
	assign issuing   = (state_q == ST_MAC) && (issue_q < comps_eff);
	assign mac_done  = (state_q == ST_MAC) && !issuing && !rd_s1;
	assign emit_load = (state_q == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
	assign emit_last = ({1'b0, emit_k_q} == (comps_eff - COMPS_CFG_W'(1)));

	// Table memories.
	logic [COEF_W-1:0]  mean_rdata;
	logic [COEF_W-1:0]  w_rdata;
	logic               w_re;
	logic [WADDR_W-1:0] w_raddr;

	assign w_re    = (state_q == ST_MEAN) || issuing;
	assign w_raddr = {issue_q[COMP_W-1:0], elem_q};

	pce_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_DIMS)
	) u_mean_ram (
		.clk   (clk),
		.we    (s_accept && (in_cmd == CMD_LOAD_MEAN)),
		.waddr (in_elem),
		.wdata (in_coef),
		.re    (s_accept),
		.raddr (in_elem),
		.rdata (mean_rdata)
	);

	pce_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_DIMS * COMP_SLOTS)
	) u_weight_ram (
		.clk   (clk),
		.we    (s_accept && (in_cmd == CMD_LOAD_WEIGHT)),
		.waddr ({in_comp, in_elem}),
		.wdata (in_coef),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= '0;
			emit_k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && sample_ok) begin
						// Component 0 is read while the mean is used to form the difference.
						issue_q <= '0;
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					issue_q <= COMPS_CFG_W'(1);
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (issuing) begin
						issue_q <= issue_q + COMPS_CFG_W'(1);
					end
					if (mac_done) begin
						emit_k_q <= '0;
						state_q  <= last_elem_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						emit_k_q <= emit_k_q + COMP_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample item capture.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			elem_q      <= in_elem;
			byte_q      <= in_byte;
			last_elem_q <= ({1'b0, in_elem} == (dims_eff - DIMS_CFG_W'(1)));
		end
	end

	// Difference of the byte (as Q8.8) and the element's mean.
	logic signed [DIFF_W-1:0] diff_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN) begin
			diff_q <= $signed({2'b00, byte_q, 8'h00})
				- $signed({{(DIFF_W-COEF_W){mean_rdata[COEF_W-1]}}, mean_rdata});
		end
	end

	// Multiply-accumulate pipeline: weight read, product, accumulate.
	logic [COMP_W-1:0]        k_s1;
	logic                     v_s2;
	logic [COMP_W-1:0]        k_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]         acc_q [COMP_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			rd_s1 <= w_re;
			v_s2  <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= issue_q[COMP_W-1:0];
		if (rd_s1) begin
			k_s2    <= k_s1;
			prod_s2 <= diff_q * $signed(w_rdata);
		end
	end

	// Accumulators: add one product a cycle, clear all after the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMP_SLOTS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (emit_load && emit_last) begin
			for (int i = 0; i < COMP_SLOTS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[k_s2] <= acc_q[k_s2]
				+ {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// Output register.
	logic                 m_valid_q;
	logic [COMP_W-1:0]    m_num_q;
	logic [ACC_W-1:0]     m_proj_q;
	logic                 m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_num_q  <= emit_k_q;
			m_proj_q <= acc_q[emit_k_q];
			m_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-ACC_W-COMP_W){1'b0}}, m_proj_q, m_num_q};
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	// No multiply-accumulate is in flight while the block takes items.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!rd_s1 && !v_s2))
		else $error("MAC pipeline busy while ready");

	// Products reach the accumulators only during the MAC phase.
	a_acc_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_MAC))
		else $error("accumulate outside MAC phase");

	// The mean read is always followed by the MAC phase.
	a_mean_to_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEAN) |=> (state_q == ST_MAC))
		else $error("mean state not followed by MAC");

	// The last result returns the sequencer to idle with cleared accumulators.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> ((state_q == ST_IDLE) && (acc_q[0] == '0) && m_axis_tlast))
		else $error("last result did not close the descriptor");
`endif

endmodule

### hdl/pce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
